// ===== hdl/pfc_pkg.sv =====
package pfc_pkg;

    typedef enum logic [3:0] {
        FMT_GRAY1   = 4'd0,
        FMT_GRAY2   = 4'd1,
        FMT_GRAY4   = 4'd2,
        FMT_GRAY8   = 4'd3,
        FMT_RGB565  = 4'd4,
        FMT_RGB888  = 4'd5,
        FMT_ARGB    = 4'd6,
        FMT_RGBA    = 4'd7,
        FMT_ARGB_SW = 4'd8,
        FMT_RGBA_SW = 4'd9
    } t_fmt;

    typedef enum logic [1:0] {
        KIND_CONV = 2'd0,
        KIND_PASS = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_FORMAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE   = 3'd4;

    localparam t_fmt       RST_SOURCE_FORMAT = FMT_RGB888;
    localparam t_fmt       RST_TARGET_FORMAT = FMT_GRAY8;
    localparam logic [7:0] RST_WEIGHT_RED    = 8'd80;
    localparam logic [7:0] RST_WEIGHT_GREEN  = 8'd144;
    localparam logic [7:0] RST_WEIGHT_BLUE   = 8'd32;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_weights;

    typedef struct packed {
        t_fmt     source;
        t_fmt     target;
        t_weights weights;
    } t_cfg;

    // one classified pixel, as it sits in the queue
    typedef struct packed {
        t_kind       kind;
        t_fmt        target;
        logic [31:0] pixel;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } t_item;

endpackage

// ===== hdl/pfc_front.sv =====
module pfc_front (
    input  pfc_pkg::t_cfg  i_cfg,
    input  logic           i_start,
    input  logic           i_full,
    input  logic [31:0]    i_pixel_in,
    output logic           o_push,
    output pfc_pkg::t_item o_item
);
    import pfc_pkg::*;

    logic [31:0] p;

    assign p      = i_pixel_in;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_item        = '0;
        o_item.pixel  = p;
        o_item.target = i_cfg.target;
        o_item.a      = 8'hff;

        if (i_cfg.source > FMT_RGBA_SW) begin
            o_item.kind = KIND_BAD;
        end else if (i_cfg.source == i_cfg.target) begin
            o_item.kind = KIND_PASS;
        end else if (i_cfg.target > FMT_RGBA) begin
            o_item.kind = KIND_BAD;
        end else begin
            o_item.kind = KIND_CONV;
        end

        unique case (i_cfg.source)
            FMT_GRAY1: begin
                o_item.r = {8{p[0]}};
                o_item.g = {8{p[0]}};
                o_item.b = {8{p[0]}};
            end
            FMT_GRAY2: begin
                o_item.r = {4{p[1:0]}};
                o_item.g = {4{p[1:0]}};
                o_item.b = {4{p[1:0]}};
            end
            FMT_GRAY4: begin
                o_item.r = {2{p[3:0]}};
                o_item.g = {2{p[3:0]}};
                o_item.b = {2{p[3:0]}};
            end
            FMT_GRAY8: begin
                o_item.r = p[7:0];
                o_item.g = p[7:0];
                o_item.b = p[7:0];
            end
            FMT_RGB565: begin
                // top bits replicated into the low end of each channel
                o_item.r = {p[15:11], p[15:13]};
                o_item.g = {p[10:5], p[10:9]};
                o_item.b = {p[4:0], p[4:2]};
            end
            FMT_RGB888: begin
                o_item.r = p[23:16];
                o_item.g = p[15:8];
                o_item.b = p[7:0];
            end
            FMT_ARGB: begin
                o_item.a = p[31:24];
                o_item.r = p[23:16];
                o_item.g = p[15:8];
                o_item.b = p[7:0];
            end
            FMT_RGBA: begin
                o_item.r = p[31:24];
                o_item.g = p[23:16];
                o_item.b = p[15:8];
                o_item.a = p[7:0];
            end
            FMT_ARGB_SW: begin
                o_item.b = p[31:24];
                o_item.g = p[23:16];
                o_item.r = p[15:8];
                o_item.a = p[7:0];
            end
            FMT_RGBA_SW: begin
                o_item.a = p[31:24];
                o_item.b = p[23:16];
                o_item.g = p[15:8];
                o_item.r = p[7:0];
            end
            default: begin
                o_item.r = 8'h00;
            end
        endcase
    end

endmodule

// ===== hdl/pfc_queue.sv =====
module pfc_queue #(
    parameter int DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pfc_pkg::t_item i_push_item,
    input  logic           i_pop,
    output pfc_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);
    import pfc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ===== hdl/pfc_back.sv =====
module pfc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfc_pkg::t_weights i_weights,
    input  logic              i_valid,
    input  pfc_pkg::t_item    i_item,
    output logic              o_done,
    output logic [31:0]       o_pixel_out,
    output logic              o_bad_combination
);
    import pfc_pkg::*;

    // stage 1: weighted channels
    logic        r_s1_valid;
    t_item       r_s1_item;
    logic [15:0] r_prod_r, r_prod_g, r_prod_b;

    // stage 2: luma, packing, output register
    logic [17:0] sum;
    logic [9:0]  y_wide;
    logic [7:0]  y;
    logic [31:0] n_pixel;
    logic        n_bad;
    logic        r_done;
    logic [31:0] r_pixel;
    logic        r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_item;
        r_prod_r  <= i_weights.red * i_item.r;
        r_prod_g  <= i_weights.green * i_item.g;
        r_prod_b  <= i_weights.blue * i_item.b;
    end

    assign sum    = {2'b00, r_prod_r} + {2'b00, r_prod_g} + {2'b00, r_prod_b};
    assign y_wide = sum[17:8];
    assign y      = (|y_wide[9:8]) ? 8'hff : y_wide[7:0];

    always_comb begin
        n_pixel = '0;
        n_bad   = 1'b0;
        unique case (r_s1_item.kind)
            KIND_PASS: begin
                n_pixel = r_s1_item.pixel;
            end
            KIND_BAD: begin
                n_bad = 1'b1;
            end
            KIND_CONV: begin
                unique case (r_s1_item.target)
                    FMT_GRAY1:  n_pixel = {31'd0, y[7]};
                    FMT_GRAY2:  n_pixel = {30'd0, y[7:6]};
                    FMT_GRAY4:  n_pixel = {28'd0, y[7:4]};
                    FMT_GRAY8:  n_pixel = {24'd0, y};
                    FMT_RGB565: n_pixel = {16'd0, r_s1_item.r[7:3],
                                           r_s1_item.g[7:2], r_s1_item.b[7:3]};
                    FMT_ARGB:   n_pixel = {r_s1_item.a, r_s1_item.r,
                                           r_s1_item.g, r_s1_item.b};
                    FMT_RGB888: n_pixel = {8'd0, r_s1_item.r,
                                           r_s1_item.g, r_s1_item.b};
                    default:    n_pixel = {r_s1_item.r, r_s1_item.g,
                                           r_s1_item.b, r_s1_item.a};
                endcase
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
        r_bad   <= n_bad;
    end

    assign o_done            = r_done;
    assign o_pixel_out       = r_pixel;
    assign o_bad_combination = r_done && r_bad;

endmodule

// ===== hdl/pixel_format_converter.sv =====
// Throughput: one pixel per clock cycle, sustained while busy is low; an accepted pixel
//   passes the queue register, the luma multiply stage and the output register before
//   o_done is high with its result, and the queue holds QUEUE_DEPTH items.
// busy is high only while that queue is full; results cannot stall, so it stays low if QUEUE_DEPTH > 1.
// Reset (synchronous, active low) loads the default formats and weights and empties the
//   queue and the back-end pipeline.
module pixel_format_converter #(
    parameter int QUEUE_DEPTH = pfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    i_pixel_in,
    output logic                           o_done,
    output logic [31:0]                    o_pixel_out,
    output logic                           o_bad_combination
);
    import pfc_pkg::*;

    t_cfg  r_cfg;
    logic  push, full, empty;
    t_item front_item, head_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source        <= RST_SOURCE_FORMAT;
            r_cfg.target        <= RST_TARGET_FORMAT;
            r_cfg.weights.red   <= RST_WEIGHT_RED;
            r_cfg.weights.green <= RST_WEIGHT_GREEN;
            r_cfg.weights.blue  <= RST_WEIGHT_BLUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_FORMAT: r_cfg.source        <= t_fmt'(i_cfg_data[3:0]);
                REG_TARGET_FORMAT: r_cfg.target        <= t_fmt'(i_cfg_data[3:0]);
                REG_WEIGHT_RED:    r_cfg.weights.red   <= i_cfg_data;
                REG_WEIGHT_GREEN:  r_cfg.weights.green <= i_cfg_data;
                REG_WEIGHT_BLUE:   r_cfg.weights.blue  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = full;

    pfc_front u_front (
        .i_cfg      (r_cfg),
        .i_start    (start),
        .i_full     (full),
        .i_pixel_in (i_pixel_in),
        .o_push     (push),
        .o_item     (front_item)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (front_item),
        .i_pop       (!empty),
        .o_head      (head_item),
        .o_empty     (empty),
        .o_full      (full)
    );

    pfc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_weights         (r_cfg.weights),
        .i_valid           (!empty),
        .i_item            (head_item),
        .o_done            (o_done),
        .o_pixel_out       (o_pixel_out),
        .o_bad_combination (o_bad_combination)
    );

endmodule

// ===== hdl/pfc_checker.sv =====
module pfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [31:0] o_pixel_out,
    input logic        o_bad_combination
);

    logic accept;

    assign accept = start && !busy;

    // every accepted transaction returns a result through the queue, stage-1 and output registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("result missing three cycles after accept");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3) && $past(i_rst_n, 3))
        else $error("result without a matching transaction");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_bad_combination) |-> (o_pixel_out == 32'd0))
        else $error("error result carries a nonzero pixel");

    a_bad_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bad_combination |-> o_done)
        else $error("error flag outside a result");

endmodule

bind pixel_format_converter pfc_checker u_pfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_pixel_out       (o_pixel_out),
    .o_bad_combination (o_bad_combination)
);

// ===== dv/pixel_format_converter_tb.sv =====
`timescale 1ns / 100ps

module pixel_format_converter_tb;
    import pfc_pkg::*;

    localparam int RANDOM_PIXELS = 700;
    localparam int CALM_PIXELS   = 100;

    // Expected converter output, predicted from the register copy below.
    class pfc_scoreboard;
        typedef struct {
            logic [31:0] pixel;
            logic        bad;
        } t_conv;

        logic [3:0] src_fmt;
        logic [3:0] dst_fmt;
        logic [7:0] w_red;
        logic [7:0] w_green;
        logic [7:0] w_blue;
        t_conv      expected_pixels[$];
        int         errors;

        function new();
            src_fmt = RST_SOURCE_FORMAT;
            dst_fmt = RST_TARGET_FORMAT;
            w_red   = RST_WEIGHT_RED;
            w_green = RST_WEIGHT_GREEN;
            w_blue  = RST_WEIGHT_BLUE;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SOURCE_FORMAT: src_fmt = data[3:0];
                REG_TARGET_FORMAT: dst_fmt = data[3:0];
                REG_WEIGHT_RED:    w_red   = data;
                REG_WEIGHT_GREEN:  w_green = data;
                REG_WEIGHT_BLUE:   w_blue  = data;
                default: ;
            endcase
        endfunction

        function t_conv convert_pixel(logic [31:0] px);
            t_conv       res;
            logic [7:0]  r;
            logic [7:0]  g;
            logic [7:0]  b;
            logic [7:0]  a;
            logic [17:0] luma_sum;
            logic [7:0]  y;
            res.pixel = '0;
            res.bad   = 1'b0;
            r = '0;
            g = '0;
            b = '0;
            a = 8'hff;
            if (src_fmt > FMT_RGBA_SW) begin
                res.bad = 1'b1;
                return res;
            end
            if (src_fmt == dst_fmt) begin
                res.pixel = px;
                return res;
            end
            // swapped forms are source-only
            if (dst_fmt > FMT_RGBA) begin
                res.bad = 1'b1;
                return res;
            end
            case (src_fmt)
                FMT_GRAY1: begin
                    r = {8{px[0]}}; g = r; b = r;
                end
                FMT_GRAY2: begin
                    r = {4{px[1:0]}}; g = r; b = r;
                end
                FMT_GRAY4: begin
                    r = {2{px[3:0]}}; g = r; b = r;
                end
                FMT_GRAY8: begin
                    r = px[7:0]; g = r; b = r;
                end
                FMT_RGB565: begin
                    r = {px[15:11], px[15:13]};
                    g = {px[10:5], px[10:9]};
                    b = {px[4:0], px[4:2]};
                end
                FMT_RGB888: begin
                    r = px[23:16]; g = px[15:8]; b = px[7:0];
                end
                FMT_ARGB: begin
                    a = px[31:24]; r = px[23:16]; g = px[15:8]; b = px[7:0];
                end
                FMT_RGBA: begin
                    r = px[31:24]; g = px[23:16]; b = px[15:8]; a = px[7:0];
                end
                FMT_ARGB_SW: begin
                    b = px[31:24]; g = px[23:16]; r = px[15:8]; a = px[7:0];
                end
                default: begin
                    a = px[31:24]; b = px[23:16]; g = px[15:8]; r = px[7:0];
                end
            endcase
            luma_sum = 18'(w_red) * 18'(r) + 18'(w_green) * 18'(g) + 18'(w_blue) * 18'(b);
            y = (luma_sum[17:8] > 10'd255) ? 8'hff : luma_sum[15:8];
            case (dst_fmt)
                FMT_GRAY1:  res.pixel = 32'(y[7]);
                FMT_GRAY2:  res.pixel = 32'(y[7:6]);
                FMT_GRAY4:  res.pixel = 32'(y[7:4]);
                FMT_GRAY8:  res.pixel = 32'(y);
                FMT_RGB565: res.pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
                FMT_RGB888: res.pixel = {8'd0, r, g, b};
                FMT_ARGB:   res.pixel = {a, r, g, b};
                default:    res.pixel = {r, g, b, a};
            endcase
            return res;
        endfunction

        function void note_pixel(logic [31:0] px);
            expected_pixels.push_back(convert_pixel(px));
        endfunction

        function void check_result(logic [31:0] px, logic bad);
            t_conv want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_out %08h bad_combination %0b", px, bad);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (px !== want.pixel) begin
                $error("pixel_out: expected %08h, actual %08h", want.pixel, px);
                errors++;
            end
            if (bad !== want.bad) begin
                $error("bad_combination: expected %0b, actual %0b", want.bad, bad);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic [31:0]           i_pixel_in  = '0;
    logic                  o_done;
    logic [31:0]           o_pixel_out;
    logic                  o_bad_combination;

    pfc_scoreboard conv_sb = new();

    pixel_format_converter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .start             (start),
        .busy              (busy),
        .i_pixel_in        (i_pixel_in),
        .o_done            (o_done),
        .o_pixel_out       (o_pixel_out),
        .o_bad_combination (o_bad_combination)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            conv_sb.check_result(o_pixel_out, o_bad_combination);
    end

    // start stays high on return so back-to-back transactions need no dip
    task automatic send_pixel(logic [31:0] px);
        @(negedge i_clk);
        start      = 1'b1;
        i_pixel_in = px;
        do begin
            @(posedge i_clk);
        end while (busy);
        conv_sb.note_pixel(px);
    endtask

    task automatic idle_cycles(int n);
        @(negedge i_clk);
        start = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (conv_sb.expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        conv_sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // format registers only use the low nibble; upper data bits are junk on purpose
    task automatic configure(logic [3:0] src, logic [3:0] tgt,
                             logic [7:0] wr, logic [7:0] wg, logic [7:0] wb);
        wait_drained();
        write_reg(REG_SOURCE_FORMAT, {4'($urandom), src});
        write_reg(REG_TARGET_FORMAT, {4'($urandom), tgt});
        write_reg(REG_WEIGHT_RED, wr);
        write_reg(REG_WEIGHT_GREEN, wg);
        write_reg(REG_WEIGHT_BLUE, wb);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_WEIGHT_BLUE + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
    endtask

    function automatic logic [7:0] rand_weight();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int         sent;
        int         n;
        int         gap_odds;
        logic [3:0] src;
        logic [3:0] tgt;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // out of reset: rgb888 to gray8, default weights
        send_pixel(32'h0000_0000);
        send_pixel(32'hffff_ffff);
        send_pixel(32'h00ff_0000);
        send_pixel(32'h0000_ff00);
        send_pixel(32'h0000_00ff);

        // each source into some other target; all targets from gray1 to rgba get hit
        for (int s = FMT_GRAY1; s <= FMT_RGBA_SW; s++) begin
            configure(4'(s), 4'((s + 3) % 8), RST_WEIGHT_RED, RST_WEIGHT_GREEN,
                      RST_WEIGHT_BLUE);
            send_pixel($urandom);
        end

        // passthrough keeps the unused high bits
        configure(FMT_GRAY4, FMT_GRAY4, RST_WEIGHT_RED, RST_WEIGHT_GREEN, RST_WEIGHT_BLUE);
        send_pixel(32'hdead_beef);
        configure(FMT_RGBA_SW, FMT_RGBA_SW, 8'h00, 8'h00, 8'h00);
        send_pixel(32'h8421_1248);

        // unsupported pairs
        configure(4'hf, FMT_GRAY8, 8'hff, 8'hff, 8'hff);
        send_pixel(32'hffff_ffff);
        configure(FMT_RGB888, FMT_ARGB_SW, 8'hff, 8'hff, 8'hff);
        send_pixel(32'h0012_3456);
        configure(FMT_GRAY8, 4'hf, 8'hff, 8'hff, 8'hff);
        send_pixel(32'h0000_0080);

        // luma saturation and all-zero weights
        configure(FMT_RGB888, FMT_GRAY8, 8'hff, 8'hff, 8'hff);
        send_pixel(32'h00ff_ffff);
        send_pixel(32'h0080_4020);
        configure(FMT_ARGB, FMT_GRAY1, 8'h00, 8'h00, 8'h00);
        send_pixel(32'hffff_ffff);

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 7) == 0)
                src = 4'($urandom_range(FMT_RGBA_SW + 1, 15));
            else
                src = 4'($urandom_range(FMT_GRAY1, FMT_RGBA_SW));
            case ($urandom_range(0, 9))
                0:       tgt = src;
                1:       tgt = 4'($urandom_range(FMT_ARGB_SW, 15));
                default: tgt = 4'($urandom_range(FMT_GRAY1, FMT_RGBA));
            endcase
            configure(src, tgt, rand_weight(), rand_weight(), rand_weight());

            if (sent >= RANDOM_PIXELS - CALM_PIXELS) begin
                n        = RANDOM_PIXELS - sent;
                gap_odds = 0;
            end else begin
                n        = $urandom_range(10, 40);
                gap_odds = $urandom_range(0, 2);
            end
            for (int i = 0; i < n; i++) begin
                if (gap_odds != 0 && $urandom_range(0, 3) < gap_odds)
                    idle_cycles($urandom_range(1, 16));
                send_pixel(rand_pixel());
                sent++;
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        for (int k = 0; k < 200 && conv_sb.expected_pixels.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (conv_sb.expected_pixels.size() != 0) begin
            $error("%0d results never arrived", conv_sb.expected_pixels.size());
            conv_sb.errors++;
        end

        if (conv_sb.errors == 0)
            $display("PASS pixel_format_converter");
        else
            $display("FAIL pixel_format_converter");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAIL pixel_format_converter");
        $finish;
    end

endmodule

// ===== pixel_format_converter.f =====
hdl/pfc_pkg.sv
hdl/pfc_front.sv
hdl/pfc_queue.sv
hdl/pfc_back.sv
hdl/pixel_format_converter.sv
hdl/pfc_checker.sv
dv/pixel_format_converter_tb.sv
